// ===== hdl/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 block compression: shared package
// Widths, initial chaining value, round constants and the SHA-256 sigma
// functions used by the compression datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int WORD_W       = 32;
    localparam int NUM_CHAIN    = 8;
    localparam int CHAIN_IDX_W  = $clog2(NUM_CHAIN);
    localparam int WINDOW_DEPTH = 16;
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH);
    localparam int NUM_ROUNDS   = 64;
    localparam int ROUND_W      = $clog2(NUM_ROUNDS);
    localparam int CFG_IDX_W    = CHAIN_IDX_W + 1;

    localparam logic [WORD_W-1:0] IV_RESET [NUM_CHAIN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_ROUND   = 4'b0010,
        ST_ADD     = 4'b0100,
        ST_EMIT    = 4'b1000
    } state_t;

    function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] idx);
        logic [WORD_W-1:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h428a2f98;
        endcase
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sha256_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message word channel
// Valid/ready channel carrying one message word and its restart flag a beat.
// ----------------------------------------------------------------------------
interface sha256_in_if;

    logic                           valid;
    logic                           ready;
    logic [sha256_pkg::WORD_W-1:0]  message_word;
    logic                           restart;

    modport source (output valid, output message_word, output restart, input ready);
    modport sink   (input valid, input message_word, input restart, output ready);

endinterface
`default_nettype wire

// ===== hdl/sha256_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 digest word channel
// Valid/ready channel carrying one chaining word, its index and a last flag.
// ----------------------------------------------------------------------------
interface sha256_out_if;

    logic                                valid;
    logic                                ready;
    logic [sha256_pkg::WORD_W-1:0]       digest_word;
    logic [sha256_pkg::CHAIN_IDX_W-1:0]  word_index;
    logic                                last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                    output ready);

endinterface
`default_nettype wire

// ===== hdl/sha256_block_compress.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 block compression
// Collects sixteen message words, runs the 64 rounds on one shared round
// datapath, folds the working variables into the chaining value and streams
// out the eight updated chaining words.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents                          handshake
//  in_ch     in   message_word[31:0], restart            valid/ready
//  out_ch    out  digest_word[31:0], word_index[2:0], last valid/ready
//  cfg       in   cfg_index[3:0], cfg_data[31:0]         cfg_write, no stall
//
//  Words 1..15 of a block fill the schedule window; the 16th starts the
//  64-round loop (one round per cycle), then eight chaining adds through
//  one adder, then eight result beats.
//  in_ch.ready is low from the 16th beat until the last result beat is taken.
//  Reset loads the standard initial value into the init and chaining words.
//
// ----------------------------------------------------------------------------
module sha256_block_compress (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [sha256_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sha256_pkg::WORD_W-1:0]       cfg_data,
    sha256_in_if.sink                                in_ch,
    sha256_out_if.source                             out_ch
);

    localparam int W   = sha256_pkg::WORD_W;
    localparam int NC  = sha256_pkg::NUM_CHAIN;
    localparam int ND  = sha256_pkg::WINDOW_DEPTH;
    localparam int CW  = sha256_pkg::COUNT_W;
    localparam int RW  = sha256_pkg::ROUND_W;
    localparam int IW  = sha256_pkg::CHAIN_IDX_W;

    localparam logic [CW-1:0] LAST_WORD  = CW'(ND - 1);
    localparam logic [RW-1:0] LAST_ROUND = RW'(sha256_pkg::NUM_ROUNDS - 1);
    localparam logic [IW-1:0] LAST_IDX   = IW'(NC - 1);

    sha256_pkg::state_t state_reg, state_next;
    logic [CW-1:0]      word_cnt_reg, word_cnt_next;
    logic [CW-1:0]      eff_cnt;
    logic [RW-1:0]      step_reg, step_next;
    logic [W-1:0]       init_reg  [NC];
    logic [W-1:0]       chain_reg [NC];
    logic [W-1:0]       chain_next[NC];
    logic [W-1:0]       v_reg     [NC];
    logic [W-1:0]       v_next    [NC];
    logic [W-1:0]       win_reg   [ND];
    logic [W-1:0]       win_next  [ND];

    logic               in_fire;
    logic               out_fire;
    logic [W-1:0]       ch_val;
    logic [W-1:0]       maj_val;
    logic [W-1:0]       t1;
    logic [W-1:0]       t2;
    logic [W-1:0]       w_new;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    assign in_ch.ready        = (state_reg == sha256_pkg::ST_COLLECT);
    assign out_ch.valid       = (state_reg == sha256_pkg::ST_EMIT);
    assign out_ch.digest_word = chain_reg[0];
    assign out_ch.word_index  = step_reg[IW-1:0];
    assign out_ch.last        = (step_reg[IW-1:0] == LAST_IDX);

    assign eff_cnt = in_ch.restart ? '0 : word_cnt_reg;

    assign ch_val  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj_val = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1      = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4]) + ch_val
                     + sha256_pkg::round_const(step_reg) + win_reg[0];
    assign t2      = sha256_pkg::big_sigma0(v_reg[0]) + maj_val;
    assign w_new   = win_reg[0] + sha256_pkg::small_sigma0(win_reg[1]) + win_reg[9]
                     + sha256_pkg::small_sigma1(win_reg[14]);

    always_comb
    begin
        state_next    = state_reg;
        word_cnt_next = word_cnt_reg;
        step_next     = step_reg;
        chain_next    = chain_reg;
        v_next        = v_reg;
        win_next      = win_reg;
        unique case (state_reg)
            sha256_pkg::ST_COLLECT:
            begin
                if (in_fire)
                begin
                    for (int i = 0; i < ND - 1; i++)
                    begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[ND-1] = in_ch.message_word;
                    if (in_ch.restart)
                    begin
                        chain_next = init_reg;
                    end
                    if (eff_cnt == LAST_WORD)
                    begin
                        word_cnt_next = '0;
                        v_next        = chain_reg;
                        step_next     = '0;
                        state_next    = sha256_pkg::ST_ROUND;
                    end
                    else
                    begin
                        word_cnt_next = eff_cnt + CW'(1);
                    end
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < ND - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[ND-1] = w_new;
                if (step_reg == LAST_ROUND)
                begin
                    step_next  = '0;
                    state_next = sha256_pkg::ST_ADD;
                end
                else
                begin
                    step_next = step_reg + RW'(1);
                end
            end
            sha256_pkg::ST_ADD:
            begin
                for (int i = 0; i < NC - 1; i++)
                begin
                    chain_next[i] = chain_reg[i+1];
                    v_next[i]     = v_reg[i+1];
                end
                chain_next[NC-1] = chain_reg[0] + v_reg[0];
                v_next[NC-1]     = v_reg[0];
                if (step_reg[IW-1:0] == LAST_IDX)
                begin
                    step_next  = '0;
                    state_next = sha256_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + RW'(1);
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                if (out_fire)
                begin
                    for (int i = 0; i < NC - 1; i++)
                    begin
                        chain_next[i] = chain_reg[i+1];
                    end
                    chain_next[NC-1] = chain_reg[0];
                    if (step_reg[IW-1:0] == LAST_IDX)
                    begin
                        step_next  = '0;
                        state_next = sha256_pkg::ST_COLLECT;
                    end
                    else
                    begin
                        step_next = step_reg + RW'(1);
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_COLLECT;
            end
        endcase
    end

    // control, chaining value and working variables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256_pkg::ST_COLLECT;
            word_cnt_reg <= '0;
            step_reg     <= '0;
            chain_reg    <= sha256_pkg::IV_RESET;
            for (int i = 0; i < NC; i++)
            begin
                v_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            word_cnt_reg <= word_cnt_next;
            step_reg     <= step_next;
            chain_reg    <= chain_next;
            v_reg        <= v_next;
        end
    end

    // initial-value registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= sha256_pkg::IV_RESET;
        end
        else if (cfg_write && (cfg_index < sha256_pkg::CFG_IDX_W'(NC)))
        begin
            init_reg[cfg_index[IW-1:0]] <= cfg_data;
        end
    end

    // schedule window
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule
`default_nettype wire

// ===== hdl/sha256_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 block compression: port checker
// Watches the channel ports of the compression block and flags ordering and
// handshake slips on the result stream.
// ----------------------------------------------------------------------------
module sha256_chk (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic [sha256_pkg::WORD_W-1:0]        digest_word,
    input wire logic [sha256_pkg::CHAIN_IDX_W-1:0]   word_index,
    input wire logic                                 last
);

    localparam logic [sha256_pkg::CHAIN_IDX_W-1:0] LAST_IDX =
        sha256_pkg::CHAIN_IDX_W'(sha256_pkg::NUM_CHAIN - 1);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while results pending");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && (word_index == $past(word_index) + 1'b1)))
        else $error("result index did not advance");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (word_index == LAST_IDX)))
        else $error("last flag out of step with index");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (in_ready && !out_valid))
        else $error("input not reopened after last result beat");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(digest_word) && $stable(word_index)))
        else $error("stalled result beat changed");

endmodule

bind sha256_block_compress sha256_chk u_sha256_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last        (out_ch.last)
);
`default_nettype wire
